[rtl/light_gesture_peak_detector_macros.svh]
// Assertion macros for the light gesture peak detector.
// Used by the port-level checker; no other dependencies.
`ifndef LIGHT_GESTURE_PEAK_DETECTOR_MACROS_SVH
`define LIGHT_GESTURE_PEAK_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LGPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LGPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lgpd_pkg.sv]
// Shared types and constants for the light gesture peak detector.
// No dependencies; every other file but the assertion macros imports this package.
package lgpd_pkg;

  localparam int ADC_W      = 10;
  localparam int SAMPLE_W   = 11;
  localparam int THR_W      = 12;
  localparam int PERIOD_W   = 16;
  localparam int LOOP_W     = 10;
  localparam int TIME_W     = 32;
  localparam int CAL_SUM_W  = 15;
  localparam int CAL_CNT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int CAL_SAMPLES = 10;
  localparam int CAL_SHIFT   = 3;
  localparam int DUR_MIN     = 150;
  localparam int DUR_MAX     = 1000;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000);
  localparam logic [LOOP_W-1:0]   LOOP_RST   = LOOP_W'(50);

  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_CAL    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP      = 2'd2;

  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [THR_W-1:0]     thr_t;
  typedef logic signed [CAL_SUM_W-1:0] cal_sum_t;

  typedef struct packed {
    logic    go;
    sample_t diff;
  } cal_req_t;

  typedef struct packed {
    logic    en;
    sample_t data;
  } win_push_t;

  typedef struct packed {
    logic done;
    logic gesture;
  } eval_res_t;

endpackage

[rtl/lgpd_sample_if.sv]
// Input item channel: valid/ready plus one sample (opcode, two readings, time).
// Depends on lgpd_pkg.
interface lgpd_sample_if;
  import lgpd_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADC_W-1:0]  adc_a;
  logic [ADC_W-1:0]  adc_b;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, opcode, adc_a, adc_b, now_ms, input ready);
  modport sink (input valid, opcode, adc_a, adc_b, now_ms, output ready);
endinterface

[rtl/lgpd_result_if.sv]
// Result item channel: valid/ready plus gesture, armed and reference level.
// Depends on lgpd_pkg.
interface lgpd_result_if;
  import lgpd_pkg::*;

  logic    valid;
  logic    ready;
  logic    gesture;
  logic    armed;
  sample_t reference_level;

  modport source (output valid, gesture, armed, reference_level, input ready);
  modport sink (input valid, gesture, armed, reference_level, output ready);
endinterface

[rtl/lgpd_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Depends on lgpd_pkg.
interface lgpd_cfg_if;
  import lgpd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/lgpd_window.sv]
// Sample window: ring-buffer memory with one write and one registered read port.
// Logical index 0 is the oldest entry; a fill count makes unwritten entries read 0.
// Depends on lgpd_pkg.
module lgpd_window #(
  parameter int WINDOW_LEN = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lgpd_pkg::win_push_t           push,
  input  logic                          rd_en,
  input  logic [$clog2(WINDOW_LEN)-1:0] rd_idx,
  output lgpd_pkg::sample_t             rd_data
);
  import lgpd_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam logic [IDX_W:0]   LEN_P   = (IDX_W + 1)'(WINDOW_LEN);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W-1:0] FULL    = CNT_W'(WINDOW_LEN);
  localparam logic [CNT_W:0]   LEN_CNT = (CNT_W + 1)'(WINDOW_LEN);

  sample_t          mem [WINDOW_LEN];
  sample_t          mem_q;
  logic             live_q;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] fill;
  logic [IDX_W:0]   phys_sum;
  logic [IDX_W-1:0] phys;
  logic [CNT_W:0]   vis_sum;

  assign phys_sum = {1'b0, head} + {1'b0, rd_idx};
  assign phys     = (phys_sum >= LEN_P) ? IDX_W'(phys_sum - LEN_P) : phys_sum[IDX_W-1:0];
  // Entry is visible once it has been written since reset
  assign vis_sum  = (CNT_W + 1)'(rd_idx) + (CNT_W + 1)'(fill);

  always_ff @(posedge clk) begin
    if (push.en) begin
      mem[head] <= push.data;
    end
    if (rd_en) begin
      mem_q <= mem[phys];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      fill   <= '0;
      live_q <= 1'b0;
    end else begin
      if (push.en) begin
        head <= (head == LAST) ? '0 : head + 1'b1;
        if (fill != FULL) begin
          fill <= fill + 1'b1;
        end
      end
      if (rd_en) begin
        live_q <= (vis_sum >= LEN_CNT);
      end
    end
  end

  assign rd_data = live_q ? mem_q : '0;

endmodule

[rtl/lgpd_cal.sv]
// Calibration accumulator: ten samples, drop min and max, divide by 8 toward zero.
// Holds the reference level. Depends on lgpd_pkg.
module lgpd_cal (
  input  logic               clk,
  input  logic               rst,
  input  lgpd_pkg::cal_req_t req,
  output lgpd_pkg::sample_t  reference_value
);
  import lgpd_pkg::*;

  localparam logic [CAL_CNT_W-1:0] CNT_LAST = CAL_CNT_W'(CAL_SAMPLES - 1);
  localparam cal_sum_t             BIAS     = cal_sum_t'((1 << CAL_SHIFT) - 1);

  logic [CAL_CNT_W-1:0] cnt;
  cal_sum_t             sum;
  sample_t              cmin;
  sample_t              cmax;
  logic                 fin;

  logic     first;
  cal_sum_t sum_base;
  sample_t  min_base;
  sample_t  max_base;
  cal_sum_t trim;
  cal_sum_t biased;

  assign first    = (cnt == '0);
  assign sum_base = first ? '0 : sum;
  assign min_base = first ? req.diff : cmin;
  assign max_base = first ? req.diff : cmax;
  assign trim     = sum - cal_sum_t'(cmin) - cal_sum_t'(cmax);
  // bias negative values so the arithmetic shift truncates toward zero
  assign biased   = trim + (trim[CAL_SUM_W-1] ? BIAS : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt             <= '0;
      sum             <= '0;
      cmin            <= '0;
      cmax            <= '0;
      fin             <= 1'b0;
      reference_value <= '0;
    end else begin
      fin <= req.go && (cnt == CNT_LAST);
      if (req.go) begin
        sum  <= sum_base + cal_sum_t'(req.diff);
        cmin <= (req.diff < min_base) ? req.diff : min_base;
        cmax <= (req.diff > max_base) ? req.diff : max_base;
        if (cnt == CNT_LAST) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (fin) begin
        reference_value <= sample_t'(biased >>> CAL_SHIFT);
      end
    end
  end

endmodule

[rtl/lgpd_eval.sv]
// Window evaluation sequencer: peak search, rising and falling slope scans,
// duration check through one shared multiplier. Reads the window memory.
// Depends on lgpd_pkg.
module lgpd_eval #(
  parameter int WINDOW_LEN = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lgpd_pkg::LOOP_W-1:0]   loop_ms,
  output logic                          rd_en,
  output logic [$clog2(WINDOW_LEN)-1:0] rd_idx,
  input  lgpd_pkg::sample_t             rd_data,
  output lgpd_pkg::eval_res_t           res
);
  import lgpd_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int C_W   = IDX_W + 1;
  localparam int P_W   = C_W + LOOP_W;
  localparam logic [C_W-1:0] LEN_C     = C_W'(WINDOW_LEN);
  localparam logic [C_W-1:0] LAST      = C_W'(WINDOW_LEN - 1);
  localparam logic [C_W-1:0] LAST_PEAK = C_W'(WINDOW_LEN - 2);
  localparam logic [P_W-1:0] P_MIN     = P_W'(DUR_MIN);
  localparam logic [P_W-1:0] P_MAX     = P_W'(DUR_MAX);

  typedef enum logic [2:0] {
    E_IDLE,
    E_PEAK,
    E_RISE,
    E_MUL,
    E_CMP,
    E_FALL
  } state_t;

  state_t         state;
  logic [C_W-1:0] cnt;
  logic           q_live;
  logic [C_W-1:0] q_idx;
  logic [C_W-1:0] peak;
  sample_t        peak_val;
  sample_t        prev;
  logic [C_W-1:0] span;
  logic [P_W-1:0] prod;
  logic           on_fall;

  logic           take;
  logic [C_W-1:0] peak_sel;
  logic           prod_bad;

  // first maximum wins: only a strictly larger entry moves the peak
  assign take     = (q_idx == '0) || (rd_data > peak_val);
  assign peak_sel = take ? q_idx : peak;
  assign rd_idx   = cnt[IDX_W-1:0];
  assign prod_bad = (prod < P_MIN) || (prod > P_MAX);

  always_comb begin
    unique case (state)
      E_PEAK:  rd_en = (cnt <= LAST_PEAK);
      E_RISE:  rd_en = (cnt <= LAST);
      E_FALL:  rd_en = !cnt[C_W-1];
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      q_live <= 1'b0;
      res    <= '0;
    end else begin
      res.done <= (state == E_CMP) && (prod_bad || on_fall);
      q_live   <= rd_en;
      q_idx    <= cnt;
      if (rd_en) begin
        cnt <= (state == E_FALL) ? cnt - 1'b1 : cnt + 1'b1;
      end
      unique case (state)
        E_IDLE: begin
          if (start) begin
            cnt   <= '0;
            state <= E_PEAK;
          end
        end
        E_PEAK: begin
          if (q_live) begin
            if (take) begin
              peak     <= q_idx;
              peak_val <= rd_data;
            end
            if (q_idx == LAST_PEAK) begin
              prev  <= take ? rd_data : peak_val;
              cnt   <= peak_sel + 1'b1;
              state <= E_RISE;
            end
          end
        end
        E_RISE: begin
          if (q_live) begin
            if (rd_data > prev) begin
              span    <= q_idx - peak;
              on_fall <= 1'b0;
              state   <= E_MUL;
            end else begin
              prev <= rd_data;
              if (q_idx == LAST) begin
                span    <= LEN_C - peak;
                on_fall <= 1'b0;
                state   <= E_MUL;
              end
            end
          end
        end
        E_MUL: begin
          prod  <= P_W'(span) * P_W'(loop_ms);
          state <= E_CMP;
        end
        E_CMP: begin
          if (prod_bad) begin
            res.gesture <= 1'b0;
            state       <= E_IDLE;
          end else if (on_fall) begin
            res.gesture <= 1'b1;
            state       <= E_IDLE;
          end else if (peak == '0) begin
            // peak at the oldest entry: falling side counts as one step
            span    <= C_W'(1);
            on_fall <= 1'b1;
            state   <= E_MUL;
          end else begin
            cnt     <= peak - 1'b1;
            prev    <= peak_val;
            on_fall <= 1'b1;
            state   <= E_FALL;
          end
        end
        E_FALL: begin
          if (q_live) begin
            if (rd_data > prev) begin
              span  <= peak - q_idx - 1'b1;
              state <= E_MUL;
            end else begin
              prev <= rd_data;
              if (q_idx == '0) begin
                span  <= peak;
                state <= E_MUL;
              end
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

[rtl/light_gesture_peak_detector.sv]
// Light gesture peak detector. Each input item is a calibration sample or a
// detection sample (difference of two light readings) and yields exactly one
// result item: gesture flag, armed flag and the current reference level. A
// new item is accepted only once the result of the last one has been registered.
// An evaluation item walks the window memory through its single read port, one
// entry per cycle: peak search over WINDOW_LEN-1 entries, then the slope scans.
// The window needs no clearing pass after reset; entries not yet written read
// as zero.
// Depends on lgpd_pkg, the channel interfaces, lgpd_window, lgpd_cal, lgpd_eval.
module light_gesture_peak_detector #(
  parameter int WINDOW_LEN = 50
) (
  input  logic          clk,
  input  logic          rst,
  lgpd_sample_if.sink   sample,
  lgpd_result_if.source result,
  lgpd_cfg_if.sink      cfg
);
  import lgpd_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LEN);

  typedef enum logic [2:0] {
    T_IDLE,
    T_CAL,
    T_CALFIN,
    T_DET,
    T_EVAL,
    T_OUT
  } state_t;

  state_t              state;
  sample_t             diff_r;
  logic [TIME_W-1:0]   now_r;
  logic                gesture_r;
  thr_t                threshold;
  logic [PERIOD_W-1:0] period;
  logic [LOOP_W-1:0]   loop_ms;
  logic                armed_flag;
  logic [TIME_W-1:0]   trigger_time;

  cal_req_t          cal_req;
  win_push_t         push;
  eval_res_t         eval_res;
  logic              eval_start;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  sample_t           rd_data;
  sample_t           reference_value;

  logic [TIME_W-1:0] elapsed;
  logic              due;
  thr_t              delta;
  logic              fire;

  assign elapsed = now_r - trigger_time;
  assign due     = !armed_flag && (elapsed >= TIME_W'(period));
  assign delta   = thr_t'(reference_value) - thr_t'(diff_r);
  assign fire    = threshold[THR_W-1] ? (delta < threshold) : (delta > threshold);

  assign sample.ready = (state == T_IDLE);
  assign cfg.ready    = 1'b1;

  assign cal_req.go   = (state == T_CAL);
  assign cal_req.diff = diff_r;
  assign push.en      = (state == T_DET) && !due;
  assign push.data    = diff_r;
  assign eval_start   = (state == T_DET) && due;

  lgpd_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  lgpd_cal u_cal (
    .clk             (clk),
    .rst             (rst),
    .req             (cal_req),
    .reference_value (reference_value)
  );

  lgpd_eval #(.WINDOW_LEN(WINDOW_LEN)) u_eval (
    .clk     (clk),
    .rst     (rst),
    .start   (eval_start),
    .loop_ms (loop_ms),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .res     (eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      period    <= PERIOD_RST;
      loop_ms   <= LOOP_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_THRESHOLD: threshold <= thr_t'(cfg.data[THR_W-1:0]);
        CFG_PERIOD:    period    <= cfg.data[PERIOD_W-1:0];
        CFG_LOOP:      loop_ms   <= cfg.data[LOOP_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      armed_flag   <= 1'b1;
      trigger_time <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != T_OUT) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (sample.valid) begin
            diff_r    <= sample_t'({1'b0, sample.adc_a}) - sample_t'({1'b0, sample.adc_b});
            now_r     <= sample.now_ms;
            gesture_r <= 1'b0;
            state     <= (sample.opcode == OP_CAL) ? T_CAL : T_DET;
          end
        end
        T_CAL:    state <= T_CALFIN;
        T_CALFIN: state <= T_OUT;
        T_DET: begin
          if (due) begin
            // evaluation step: re-arm, leave the window as is
            armed_flag <= 1'b1;
            state      <= T_EVAL;
          end else begin
            if (armed_flag && fire) begin
              trigger_time <= now_r;
              armed_flag   <= 1'b0;
            end
            state <= T_OUT;
          end
        end
        T_EVAL: begin
          if (eval_res.done) begin
            gesture_r <= eval_res.gesture;
            state     <= T_OUT;
          end
        end
        T_OUT: begin
          // hold until the output register is free
          if (!result.valid || result.ready) begin
            result.valid           <= 1'b1;
            result.gesture         <= gesture_r;
            result.armed           <= armed_flag;
            result.reference_level <= reference_value;
            state                  <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

[rtl/lgpd_checker.sv]
// Port-level checker for the light gesture peak detector, bound to the top level.
// Depends on lgpd_pkg and light_gesture_peak_detector_macros.svh.
`include "light_gesture_peak_detector_macros.svh"

module lgpd_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              gesture,
  input logic              armed,
  input lgpd_pkg::sample_t reference_level
);
  import lgpd_pkg::*;

  localparam sample_t REF_OUT_OF_RANGE = sample_t'(-1024);

  // one item in flight: ready drops right after an accept
  `LGPD_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "accepted while busy")

  `LGPD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(gesture) && $stable(armed) && $stable(reference_level), "stalled result changed")

  // evaluation always re-arms
  `LGPD_ASSERT_NOW(a_gesture_armed, clk, rst, out_valid && gesture, armed, "gesture while disarmed")

  `LGPD_ASSERT_NOW(a_ref_range, clk, rst, out_valid, reference_level != REF_OUT_OF_RANGE, "reference out of range")

endmodule

bind light_gesture_peak_detector lgpd_checker u_lgpd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (sample.valid),
  .in_ready        (sample.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .gesture         (result.gesture),
  .armed           (result.armed),
  .reference_level (result.reference_level)
);

[tb/lgpd_outcome_checker.sv]
// Scoreboard for the light gesture peak detector: tracks calibration, window and
// trigger state from accepted items and compares every result item in order.
// Depends on lgpd_pkg and the sample, result and cfg channel interfaces.
module lgpd_outcome_checker #(
  parameter int WINDOW_LEN = 50
) (
  input  logic   clk,
  input  logic   rst,
  lgpd_sample_if smp_ch,
  lgpd_result_if res_ch,
  lgpd_cfg_if    cfg_ch,
  output int     errors,
  output int     pending,
  output int     results_seen,
  output int     evaluations,
  output int     gestures,
  output int     references
);
  timeunit 1ns;
  timeprecision 1ps;
  import lgpd_pkg::*;

  typedef struct packed {
    logic    gesture;
    logic    armed;
    sample_t level;
  } outcome_t;

  outcome_t            outcome_q[$];
  sample_t             win [WINDOW_LEN];
  sample_t             ref_level;
  logic                armed_now;
  logic [TIME_W-1:0]   trig_ms;
  int                  cal_n;
  int                  cal_total;
  int                  cal_lo;
  int                  cal_hi;
  thr_t                thr;
  logic [PERIOD_W-1:0] period;
  logic [LOOP_W-1:0]   loop_len;

  function automatic bit span_ok(int steps);
    int dur;
    dur = steps * int'(loop_len);
    return dur >= DUR_MIN && dur <= DUR_MAX;
  endfunction

  // Peak is the first maximum, the newest entry left out of the search.
  function automatic bit peak_shape_ok();
    int i;
    int peak;
    peak = 0;
    for (i = 0; i < WINDOW_LEN - 1; i++)
      if (win[i] > win[peak]) peak = i;
    for (i = peak + 1; i < WINDOW_LEN; i++)
      if (int'(win[i]) - int'(win[i-1]) > 0) break;
    if (!span_ok(i - peak)) return 1'b0;
    for (i = peak - 1; i > 0; i--)
      if (int'(win[i]) - int'(win[i-1]) < 0) break;
    return span_ok(peak - i);
  endfunction

  function automatic outcome_t step_detector(logic op, logic [ADC_W-1:0] a,
                                             logic [ADC_W-1:0] b, logic [TIME_W-1:0] now);
    int       diff;
    int       delta;
    int       i;
    bit       fire;
    outcome_t o;
    diff = int'(a) - int'(b);
    o.gesture = 1'b0;
    if (op == OP_CAL) begin
      if (cal_n == 0) begin
        cal_total = 0;
        cal_lo = diff;
        cal_hi = diff;
      end
      cal_total += diff;
      if (diff < cal_lo) cal_lo = diff;
      if (diff > cal_hi) cal_hi = diff;
      cal_n++;
      if (cal_n >= CAL_SAMPLES) begin
        // signed division truncates toward zero
        ref_level = sample_t'((cal_total - cal_lo - cal_hi) / (1 << CAL_SHIFT));
        cal_n = 0;
        references++;
      end
    end else if (!armed_now && (now - trig_ms) >= TIME_W'(period)) begin
      // evaluation step: re-arm, leave the window alone
      armed_now = 1'b1;
      o.gesture = peak_shape_ok();
      evaluations++;
      if (o.gesture) gestures++;
    end else begin
      for (i = 0; i < WINDOW_LEN - 1; i++)
        win[i] = win[i+1];
      win[WINDOW_LEN-1] = sample_t'(diff);
      if (armed_now) begin
        delta = int'(ref_level) - diff;
        fire = (thr < 0) ? (delta < int'(thr)) : (delta > int'(thr));
        if (fire) begin
          trig_ms = now;
          armed_now = 1'b0;
        end
      end
    end
    o.armed = armed_now;
    o.level = ref_level;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    int       i;
    if (rst) begin
      for (i = 0; i < WINDOW_LEN; i++)
        win[i] = '0;
      ref_level = '0;
      armed_now = 1'b1;
      trig_ms = '0;
      cal_n = 0;
      cal_total = 0;
      cal_lo = 0;
      cal_hi = 0;
      thr = '0;
      period = PERIOD_RST;
      loop_len = LOOP_RST;
      outcome_q.delete();
      errors = 0;
      results_seen = 0;
      evaluations = 0;
      gestures = 0;
      references = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_THRESHOLD: thr = thr_t'(cfg_ch.data[THR_W-1:0]);
          CFG_PERIOD:    period = cfg_ch.data[PERIOD_W-1:0];
          CFG_LOOP:      loop_len = cfg_ch.data[LOOP_W-1:0];
          default: ;
        endcase
      end
      if (smp_ch.valid && smp_ch.ready)
        outcome_q.push_back(step_detector(smp_ch.opcode, smp_ch.adc_a, smp_ch.adc_b,
                                          smp_ch.now_ms));
      if (res_ch.valid && res_ch.ready) begin
        got.gesture = res_ch.gesture;
        got.armed = res_ch.armed;
        got.level = res_ch.reference_level;
        results_seen++;
        if (outcome_q.size() == 0) begin
          $error("result item with none expected: gesture=%0b armed=%0b reference_level=%0d",
                 got.gesture, got.armed, got.level);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (got.gesture !== want.gesture) begin
            $error("gesture: expected %0b, got %0b", want.gesture, got.gesture);
            errors++;
          end
          if (got.armed !== want.armed) begin
            $error("armed: expected %0b, got %0b", want.armed, got.armed);
            errors++;
          end
          if (got.level !== want.level) begin
            $error("reference_level: expected %0d, got %0d", want.level, got.level);
            errors++;
          end
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the light gesture peak detector bench: clock, reset, item stimulus with
// random idling on both channels, register phases, watchdog and verdict.
// Depends on lgpd_pkg, the channel interfaces, the RTL and lgpd_outcome_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lgpd_pkg::*;

  localparam int WINDOW_LEN    = 50;
  localparam int ADC_MAX       = (1 << ADC_W) - 1;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASES        = 9;

  // per phase: threshold, period, loop length (the sample spacing unless zero), item count
  int ph_thr    [PHASES] = '{-200, 150, -50, -2048, 2047, -100, -300, -150, 120};
  int ph_period [PHASES] = '{1000, 600, 0, 65535, 300, 300, 1000, 2880, 1200};
  int ph_loop   [PHASES] = '{50, 40, 1, 1023, 50, 0, 1000, 60, 50};
  int ph_items  [PHASES] = '{450, 250, 150, 80, 80, 200, 200, 250, 300};

  logic clk = 1'b0;
  logic rst;

  lgpd_sample_if smp_ch ();
  lgpd_result_if res_ch ();
  lgpd_cfg_if    cfg_ch ();

  int                errors;
  int                pending;
  int                results_seen;
  int                evaluations;
  int                gestures;
  int                references;
  logic [TIME_W-1:0] clock_ms;
  int                ref_guess;
  int                cur_thr;
  int                tick;
  int                items_sent;
  int                reg_writes;
  int                gap_pct;
  bit                calm;

  always #5 clk = ~clk;

  light_gesture_peak_detector #(.WINDOW_LEN(WINDOW_LEN)) DUT (
    .clk,
    .rst,
    .sample (smp_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  lgpd_outcome_checker #(.WINDOW_LEN(WINDOW_LEN)) outcome_chk (
    .clk,
    .rst,
    .smp_ch,
    .res_ch,
    .cfg_ch,
    .errors,
    .pending,
    .results_seen,
    .evaluations,
    .gestures,
    .references
  );

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      smp_ch.valid = 1'b0;
    end
  endtask

  // Pick readings whose difference is diff, then hold the item until accepted.
  task automatic send_sample(logic op, int diff);
    logic [ADC_W-1:0] a;
    logic [ADC_W-1:0] b;
    if (diff > ADC_MAX) diff = ADC_MAX;
    if (diff < -ADC_MAX) diff = -ADC_MAX;
    if (diff >= 0) begin
      b = ADC_W'($urandom_range(0, ADC_MAX - diff));
      a = ADC_W'(int'(b) + diff);
    end else begin
      a = ADC_W'($urandom_range(0, ADC_MAX + diff));
      b = ADC_W'(int'(a) - diff);
    end
    @(negedge clk);
    smp_ch.valid = 1'b1;
    smp_ch.opcode = op;
    smp_ch.adc_a = a;
    smp_ch.adc_b = b;
    smp_ch.now_ms = clock_ms;
    do @(posedge clk); while (smp_ch.ready !== 1'b1);
    items_sent++;
    if (!calm && rnd(0, 99) < gap_pct) idle_sender(rnd(1, 13));
  endtask

  task automatic detect(int diff);
    int step;
    step = tick;
    if (rnd(0, 9) == 0) step = rnd(0, 2 * tick);
    clock_ms += TIME_W'(step);
    send_sample(OP_DETECT, diff);
  endtask

  task automatic drain();
    @(negedge clk);
    smp_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = CFG_DATA_W'(value);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    reg_writes++;
  endtask

  task automatic cal_burst(int level, int count);
    int spread;
    spread = rnd(0, 40);
    repeat (count) begin
      clock_ms += TIME_W'(rnd(0, 3));
      if (rnd(0, 9) == 0) send_sample(OP_CAL, rnd(-ADC_MAX, ADC_MAX));
      else send_sample(OP_CAL, level + rnd(-spread, spread));
    end
    if (count == CAL_SAMPLES) ref_guess = level;
  endtask

  // Bump of random height and slope lengths on a noisy base; its polarity
  // mostly matches the trigger direction so the window gets evaluated.
  task automatic gesture_episode();
    int base;
    int amp;
    int sgn;
    int height;
    int rise;
    int fall;
    int k;
    bit clean;
    base = ref_guess + rnd(-20, 20);
    amp = rnd(0, 6);
    if (cur_thr < 0) sgn = (rnd(0, 9) < 8) ? 1 : -1;
    else sgn = (rnd(0, 9) < 8) ? -1 : 1;
    height = ((cur_thr < 0) ? -cur_thr : cur_thr) + rnd(10, 400);
    rise = rnd(1, 20);
    fall = rnd(1, 22);
    clean = rnd(0, 9) < 7;
    repeat (rnd(0, 15)) detect(base + rnd(-amp, amp));
    for (k = 1; k <= rise; k++)
      detect(base + sgn * height * k / rise + (clean ? 0 : rnd(-amp, amp)));
    for (k = 1; k <= fall; k++)
      detect(base + sgn * height * (fall - k) / fall + (clean ? 0 : rnd(-amp, amp)));
    repeat (rnd(5, 50)) detect(base + rnd(-amp, amp));
  endtask

  task automatic noise_burst();
    int kind;
    repeat (rnd(1, 6)) begin
      kind = rnd(0, 9);
      if (kind < 2) clock_ms = $urandom;
      else if (kind < 9) clock_ms += TIME_W'(tick);
      send_sample(rnd(0, 1) ? OP_CAL : OP_DETECT, rnd(-ADC_MAX, ADC_MAX));
    end
  endtask

  task automatic run_phase(int target);
    int roll;
    while (items_sent < target) begin
      case (rnd(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 8;
        default: gap_pct = 30;
      endcase
      roll = rnd(0, 99);
      if (roll < 12) cal_burst(rnd(-400, 400), (roll < 3) ? rnd(1, 9) : CAL_SAMPLES);
      else if (roll < 85) gesture_episode();
      else if (roll < 97) noise_burst();
      else if (!calm) drain();
    end
  endtask

  // result side: random stall bursts, none once the run turns calm
  initial begin
    int stall_left;
    int span;
    int stall_pct;
    stall_left = 0;
    span = 0;
    stall_pct = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        span = rnd(16, 96);
        case (rnd(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 6;
          default: stall_pct = 25;
        endcase
      end
      span--;
      if (stall_left > 0 && !calm) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
        if (!calm && rnd(0, 99) < stall_pct) stall_left = rnd(1, 13);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int cal_set [CAL_SAMPLES];
    int p;
    int i;
    cal_set = '{1023, -1023, -5, -7, 3, -9, -11, 2, -4, -6};
    rst = 1'b1;
    smp_ch.valid = 1'b0;
    smp_ch.opcode = OP_DETECT;
    smp_ch.adc_a = '0;
    smp_ch.adc_b = '0;
    smp_ch.now_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_THRESHOLD;
    cfg_ch.data = '0;
    clock_ms = '0;
    ref_guess = 0;
    cur_thr = 0;
    tick = 50;
    items_sent = 0;
    reg_writes = 0;
    gap_pct = 0;
    calm = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Reset settings: threshold 0, period 1000, loop 50.
    send_sample(OP_DETECT, ADC_MAX);
    clock_ms = 50;
    send_sample(OP_DETECT, 0);            // delta equals threshold: no trigger
    clock_ms = 100;
    send_sample(OP_DETECT, -1);           // trigger
    clock_ms = 1099;
    send_sample(OP_DETECT, -ADC_MAX);     // one ms short of the period
    // calibrate while disarmed; the sum rounds toward zero, not down
    for (i = 0; i < CAL_SAMPLES; i++)
      send_sample(OP_CAL, cal_set[i]);
    ref_guess = -4;
    clock_ms = 1100;
    send_sample(OP_DETECT, 500);          // evaluation
    // trigger just before the time wraps, evaluate just after
    clock_ms = 32'hFFFF_FF00;
    send_sample(OP_DETECT, -200);
    clock_ms = 32'h0000_02E7;
    send_sample(OP_DETECT, 7);
    clock_ms = 32'h0000_02E8;
    send_sample(OP_DETECT, 0);
    clock_ms = 32'hFFFF_FFFF;
    send_sample(OP_DETECT, 0);

    for (p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_THRESHOLD, ph_thr[p]);
      write_reg(CFG_PERIOD, ph_period[p]);
      write_reg(CFG_LOOP, ph_loop[p]);
      cur_thr = ph_thr[p];
      tick = (ph_loop[p] == 0) ? 25 : ph_loop[p];
      if (p == PHASES - 1) calm = 1'b1;
      run_phase(items_sent + ph_items[p]);
    end
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("summary: %0d items sent, %0d results checked, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("summary: %0d calibrated references, %0d window evaluations, %0d gestures",
             references, evaluations, gestures);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/lgpd_pkg.sv
rtl/lgpd_sample_if.sv
rtl/lgpd_result_if.sv
rtl/lgpd_cfg_if.sv
rtl/lgpd_window.sv
rtl/lgpd_cal.sv
rtl/lgpd_eval.sv
rtl/light_gesture_peak_detector.sv
rtl/lgpd_checker.sv
tb/lgpd_outcome_checker.sv
tb/tb_top.sv
